// ----- hw/rtl/hctp_pkg.sv -----
// ----------------------------------------------------------------------------
// hctp_pkg
// Shared types and constants for the height/color token parser: item
// payloads, the parse phase encoding and the parser state record.
// ----------------------------------------------------------------------------
package hctp_pkg;

  // color when the token carries no comma
  localparam logic [31:0] COLOR_DEFAULT = 32'h00ff_ffff;

  // parse phases
  typedef enum logic [2:0] {
    PH_H_START  = 3'd0,
    PH_H_DIGITS = 3'd1,
    PH_C_START  = 3'd2,
    PH_C_ZERO   = 3'd3,
    PH_C_DEC    = 3'd4,
    PH_C_HEX    = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  // one input item: a character and the end-of-token mark
  typedef struct packed {
    logic [7:0] char_code;
    logic       token_end;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] z_value;
    logic [31:0]        color_value;
  } out_item_t;

  // running parser state for the current token
  typedef struct packed {
    phase_t      phase;
    logic        height_negative;
    logic [31:0] height_accum;
    logic        color_negative;
    logic [31:0] color_accum;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_H_START,
    height_negative: 1'b0,
    height_accum:    32'd0,
    color_negative:  1'b0,
    color_accum:     COLOR_DEFAULT
  };

endpackage

// ----- hw/rtl/hctp_step.sv -----
// ----------------------------------------------------------------------------
// hctp_step
// Combinational update of the parser state for one character: phase
// transition plus decimal/hex accumulation of height and color.
// ----------------------------------------------------------------------------
module hctp_step
  import hctp_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   char_code,
  output parse_state_t st_next
);

  logic        is_sign;
  logic        is_minus;
  logic        is_dig;
  logic        is_comma;
  logic        is_x;
  logic        is_hex_lo;
  logic        is_hex_up;
  logic        is_hex;
  logic [31:0] dig;
  logic [31:0] hex_dig;
  logic [31:0] height_x10;
  logic [31:0] color_x10;
  logic [31:0] color_x16;
  phase_t      phase_next;

  // character classes
  assign is_minus  = (char_code == 8'h2d);
  assign is_sign   = (char_code == 8'h2b) || is_minus;
  assign is_dig    = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_comma  = (char_code == 8'h2c);
  assign is_x      = (char_code == 8'h78) || (char_code == 8'h58);
  assign is_hex_lo = (char_code >= 8'h61) && (char_code <= 8'h66);
  assign is_hex_up = (char_code >= 8'h41) && (char_code <= 8'h46);
  assign is_hex    = is_dig || is_hex_lo || is_hex_up;

  // digit values: low nibble for '0'..'9', low nibble plus nine for letters
  assign dig     = {28'd0, char_code[3:0]};
  assign hex_dig = is_dig ? dig : {28'd0, char_code[3:0] + 4'd9};

  // accumulate steps as shift-and-add
  assign height_x10 = {st.height_accum[28:0], 3'b000} + {st.height_accum[30:0], 1'b0} + dig;
  assign color_x10  = {st.color_accum[28:0], 3'b000} + {st.color_accum[30:0], 1'b0} + dig;
  assign color_x16  = {st.color_accum[27:0], 4'b0000} | hex_dig;

  // next phase
  always_comb begin
    phase_next = PH_DONE;
    unique case (st.phase) inside
      PH_H_START, PH_H_DIGITS: begin
        if ((st.phase == PH_H_START) && is_sign) phase_next = PH_H_DIGITS;
        else if (is_dig)                        phase_next = PH_H_DIGITS;
        else if (is_comma)                      phase_next = PH_C_START;
        else                                    phase_next = PH_DONE;
      end
      PH_C_START: begin
        if (is_sign)                     phase_next = PH_C_DEC;
        else if (char_code == 8'h30)     phase_next = PH_C_ZERO;
        else if (is_dig)                 phase_next = PH_C_DEC;
        else                             phase_next = PH_DONE;
      end
      PH_C_ZERO: begin
        if (is_x)        phase_next = PH_C_HEX;
        else if (is_dig) phase_next = PH_C_DEC;
        else             phase_next = PH_DONE;
      end
      PH_C_DEC: begin
        phase_next = is_dig ? PH_C_DEC : PH_DONE;
      end
      PH_C_HEX: begin
        phase_next = is_hex ? PH_C_HEX : PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // sign flags and accumulators
  always_comb begin
    st_next       = st;
    st_next.phase = phase_next;
    unique case (st.phase) inside
      PH_H_START, PH_H_DIGITS: begin
        if ((st.phase == PH_H_START) && is_sign) st_next.height_negative = is_minus;
        else if (is_dig)                        st_next.height_accum    = height_x10;
        else if (is_comma)                      st_next.color_accum     = 32'd0;
      end
      PH_C_START: begin
        if (is_sign)                            st_next.color_negative = is_minus;
        else if (is_dig && char_code != 8'h30)  st_next.color_accum    = dig;
      end
      PH_C_ZERO: begin
        if (is_dig) st_next.color_accum = dig;
      end
      PH_C_DEC: begin
        if (is_dig) st_next.color_accum = color_x10;
      end
      PH_C_HEX: begin
        if (is_hex) st_next.color_accum = color_x16;
      end
      default: begin
        st_next.color_accum = st.color_accum;
      end
    endcase
  end

endmodule

// ----- hw/rtl/height_color_token_parser.sv -----
// ----------------------------------------------------------------------------
// height_color_token_parser
// Parses map-cell tokens of the form [sign]digits[,color] into a signed
// height and a 32-bit color, one character per item.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while input ready is high, with no
// gaps between tokens. The parser state updates in the same cycle a
// character is accepted; the token's final character loads a raw result
// stage, which applies the signs into the output register once that
// register is free. Input ready drops only while both result stages are
// full and the output is stalled.
module height_color_token_parser
  import hctp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  parse_state_t st;
  parse_state_t st_upd;
  logic         in_fire;
  logic         raw_valid;
  logic         raw_adv;
  logic         raw_h_neg;
  logic         raw_c_neg;
  logic [31:0]  raw_height;
  logic [31:0]  raw_color;

  // per-character state update
  hctp_step u_step (
    .st        (st),
    .char_code (in_item.char_code),
    .st_next   (st_upd)
  );

  // handshake
  assign raw_adv  = !out_valid || out_ready;
  assign in_ready = !raw_valid || raw_adv;
  assign in_fire  = in_valid && in_ready;

  // parser state, back to reset after each token
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (in_fire) begin
      st <= in_item.token_end ? STATE_RESET : st_upd;
    end
  end

  // raw result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (in_fire && in_item.token_end) begin
      raw_valid <= 1'b1;
    end else if (raw_adv) begin
      raw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_item.token_end) begin
      raw_h_neg  <= st_upd.height_negative;
      raw_c_neg  <= st_upd.color_negative;
      raw_height <= st_upd.height_accum;
      raw_color  <= st_upd.color_accum;
    end
  end

  // output register with sign applied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (raw_adv) begin
      out_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && raw_adv) begin
      out_item.z_value     <= raw_h_neg ? (~raw_height + 32'd1) : raw_height;
      out_item.color_value <= raw_c_neg ? (~raw_color + 32'd1) : raw_color;
    end
  end

  // a final character always lands in the raw stage
  a_last_loads_raw: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.token_end) |=> raw_valid)
    else $error("final character did not produce a raw result");

  // parser restarts cleanly after a token
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.token_end) |=>
      (st.phase == PH_H_START && st.color_accum == COLOR_DEFAULT &&
       st.height_accum == 32'd0))
    else $error("parser state not reset after token");

  // a raw result moves on when the output register is free
  a_raw_moves: assert property (@(posedge clk) disable iff (rst)
    (raw_valid && !out_valid) |=> out_valid)
    else $error("raw result not forwarded to output");

  // input never taken while both result stages are held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (raw_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted with result stages full");

endmodule
